/* hdl/touch_pressure_cv_smoother_unit_defines.svh */
// Assertion macros used by the touch pressure smoother sequencer.
`ifndef TOUCH_PRESSURE_CV_SMOOTHER_UNIT_DEFINES_SVH
`define TOUCH_PRESSURE_CV_SMOOTHER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define TPCV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TPCV_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPCV_ASSERT(lbl, clk, rstn, prop, msg)
`define TPCV_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

/* hdl/tpcv_pkg.sv */
// Package with widths, constants, command and status types of the smoother.
`default_nettype none

package tpcv_pkg;

  localparam int unsigned SumW  = 20;
  localparam int unsigned CntW  = 4;
  localparam int unsigned PosW  = 4;
  localparam int unsigned MaskW = 12;
  localparam int unsigned ValW  = 16;
  localparam int unsigned DevW  = 16;
  localparam int unsigned SensW = 12;
  localparam int unsigned DenW  = 16;
  localparam int unsigned NormW = 17;
  localparam int unsigned MulW  = 17;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned AccW  = 33;
  localparam int unsigned DivCntW = 5;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 12;
  localparam logic [CfgIdxW-1:0] CfgSensorPresent = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSensitivity   = 1'b1;

  localparam logic [SensW-1:0]   SensReset  = 12'd150;
  localparam logic [ValW-1:0]    Q095       = 16'd62259;
  localparam logic [ValW-1:0]    QHalf      = 16'd32768;
  localparam logic [ValW:0]      QOne       = 17'd65536;
  // Largest 2*|change| for which 0.95 - 2*|change| stays at or above one half.
  localparam logic [ValW:0]      SmoothSpan = 17'd29491;
  localparam logic [SumW-1:0]    SumMax     = 20'sh7FFFF;
  localparam logic [SumW-1:0]    SumMin     = 20'sh80000;
  localparam logic [CntW-1:0]    CntMax     = 4'd15;
  localparam logic [PosW-1:0]    PosMax     = 4'd15;
  localparam logic [DivCntW-1:0] DivLast    = 5'(NormW - 1);

  typedef enum logic [3:0] {
    DP_NONE,
    DP_DEN,
    DP_SAT,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_TGT_ZERO,
    DP_MUL_SQ,
    DP_TGT,
    DP_SMOOTH,
    DP_MUL_HS,
    DP_MUL_TR,
    DP_BLEND,
    DP_MUL_DECAY,
    DP_DECAY
  } dp_op_e;

  typedef struct packed {
    logic   accumulate;
    logic   load_out;
    dp_op_e op;
  } tpcv_cmd_t;

  typedef struct packed {
    logic present;
    logic count_zero;
    logic sum_pos;
    logic sat;
    logic div_last;
    logic out_busy;
  } tpcv_stat_t;

endpackage

`default_nettype wire

/* hdl/tpcv_channels.sv */
// Handshake interfaces for the pad item channel and the result channel.
`default_nettype none

interface tpcv_in_if;
  logic                              valid;
  logic                              ready;
  logic                              pad_touched;
  logic signed [tpcv_pkg::DevW-1:0]  deviation;
  logic                              last_pad;

  modport source (output valid, pad_touched, deviation, last_pad, input ready);
  modport sink (input valid, pad_touched, deviation, last_pad, output ready);
endinterface

interface tpcv_out_if;
  logic                        valid;
  logic                        ready;
  logic [tpcv_pkg::MaskW-1:0]  touch_mask;
  logic [tpcv_pkg::ValW-1:0]   cv_value;

  modport source (output valid, touch_mask, cv_value, input ready);
  modport sink (input valid, touch_mask, cv_value, output ready);
endinterface

`default_nettype wire

/* hdl/tpcv_ctrl.sv */
// Sequencer of the smoother: accepts pad items and steps the end-of-poll math.
`default_nettype none
`include "touch_pressure_cv_smoother_unit_defines.svh"

module tpcv_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_last_i,
  output logic                      in_ready_o,
  input  wire tpcv_pkg::tpcv_stat_t stat_i,
  output tpcv_pkg::tpcv_cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEN    = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_SQ     = 4'd4;
  localparam logic [3:0] S_TGT    = 4'd5;
  localparam logic [3:0] S_SMOOTH = 4'd6;
  localparam logic [3:0] S_MUL1   = 4'd7;
  localparam logic [3:0] S_MUL2   = 4'd8;
  localparam logic [3:0] S_BLEND  = 4'd9;
  localparam logic [3:0] S_DECAY  = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0] state_q, state_d;
  logic       in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d          = state_q;
    cmd_o.accumulate = 1'b0;
    cmd_o.load_out   = 1'b0;
    cmd_o.op         = tpcv_pkg::DP_NONE;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accumulate = in_fire;
        if (in_fire && in_last_i) begin
          state_d = stat_i.present ? S_DEN : S_DONE;
        end
      end
      S_DEN: begin
        cmd_o.op = tpcv_pkg::DP_DEN;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.count_zero) begin
          cmd_o.op = tpcv_pkg::DP_MUL_DECAY;
          state_d  = S_DECAY;
        end else if (!stat_i.sum_pos) begin
          cmd_o.op = tpcv_pkg::DP_TGT_ZERO;
          state_d  = S_SMOOTH;
        end else if (stat_i.sat) begin
          cmd_o.op = tpcv_pkg::DP_SAT;
          state_d  = S_SQ;
        end else begin
          cmd_o.op = tpcv_pkg::DP_DIV_INIT;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.op = tpcv_pkg::DP_DIV_STEP;
        if (stat_i.div_last) begin
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.op = tpcv_pkg::DP_MUL_SQ;
        state_d  = S_TGT;
      end
      S_TGT: begin
        cmd_o.op = tpcv_pkg::DP_TGT;
        state_d  = S_SMOOTH;
      end
      S_SMOOTH: begin
        cmd_o.op = tpcv_pkg::DP_SMOOTH;
        state_d  = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.op = tpcv_pkg::DP_MUL_HS;
        state_d  = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.op = tpcv_pkg::DP_MUL_TR;
        state_d  = S_BLEND;
      end
      S_BLEND: begin
        cmd_o.op = tpcv_pkg::DP_BLEND;
        state_d  = S_DONE;
      end
      S_DECAY: begin
        cmd_o.op = tpcv_pkg::DP_DECAY;
        state_d  = S_DONE;
      end
      S_DONE: begin
        // The result waits here until the output register is free.
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `TPCV_ASSERT(a_last_leaves_idle, clk_i, rst_ni, state_q == S_IDLE && in_valid_i && in_last_i |=> state_q != S_IDLE, "last pad item did not start the poll finish")
  `TPCV_ASSERT(a_load_when_free, clk_i, rst_ni, cmd_o.load_out |-> !stat_i.out_busy, "result loaded over an unaccepted one")
  `TPCV_ASSERT(a_div_runs_out, clk_i, rst_ni, state_q == S_DIV && !stat_i.div_last |=> state_q == S_DIV, "divider left before its last step")
  `TPCV_ASSERT(a_done_to_idle, clk_i, rst_ni, state_q == S_DONE && !stat_i.out_busy |=> state_q == S_IDLE, "free output slot did not release the sequencer")
  `TPCV_ASSERT_NORST(a_reset_idle, clk_i, !rst_ni |=> state_q == S_IDLE, "sequencer not idle after reset")

endmodule

`default_nettype wire

/* hdl/tpcv_dp.sv */
// Datapath: poll accumulators, shared multiplier, restoring divider, result register.
`default_nettype none

module tpcv_dp #(
  parameter int unsigned Pads = 12
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                present_i,
  input  wire logic [tpcv_pkg::SensW-1:0]          sens_i,
  input  wire tpcv_pkg::tpcv_cmd_t                 cmd_i,
  output tpcv_pkg::tpcv_stat_t                     stat_o,
  input  wire logic                                pad_touched_i,
  input  wire logic signed [tpcv_pkg::DevW-1:0]    deviation_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic [tpcv_pkg::MaskW-1:0]               touch_mask_o,
  output logic [tpcv_pkg::ValW-1:0]                cv_value_o
);

  localparam int unsigned SumW  = tpcv_pkg::SumW;
  localparam int unsigned CntW  = tpcv_pkg::CntW;
  localparam int unsigned PosW  = tpcv_pkg::PosW;
  localparam int unsigned MaskW = tpcv_pkg::MaskW;
  localparam int unsigned ValW  = tpcv_pkg::ValW;
  localparam int unsigned DenW  = tpcv_pkg::DenW;
  localparam int unsigned NormW = tpcv_pkg::NormW;
  localparam int unsigned MulW  = tpcv_pkg::MulW;
  localparam int unsigned ProdW = tpcv_pkg::ProdW;
  localparam int unsigned AccW  = tpcv_pkg::AccW;

  // Poll accumulators and held result (control state, cleared by reset).
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [PosW-1:0]        pos_q, pos_d;
  logic [MaskW-1:0]       mask_q, mask_d;
  logic [ValW-1:0]        held_q, held_d;
  logic [MaskW-1:0]       held_mask_q, held_mask_d;
  logic                   out_valid_q, out_valid_d;
  logic [tpcv_pkg::DivCntW-1:0] div_cnt_q, div_cnt_d;

  // Working registers of the finish sequence.
  logic [DenW-1:0]  den_q, den_d;
  logic [DenW-1:0]  rem_q, rem_d;
  logic [NormW-1:0] quot_q, quot_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [ValW-1:0]  tgt_q, tgt_d;
  logic [ValW-1:0]  s_q, s_d;
  logic [MaskW-1:0] out_mask_q, out_mask_d;
  logic [ValW-1:0]  out_val_q, out_val_d;

  logic [tpcv_pkg::SensW-1:0] sens_eff;
  logic signed [SumW:0]       sum_add;
  logic [MulW-1:0]            mul_a, mul_b;
  logic [ProdW-1:0]           mul_p;
  logic [NormW-1:0]           trial;
  logic                       trial_ge;
  logic [ValW-1:0]            change;
  logic [ValW:0]              two_change;
  logic [ProdW-1:0]           blend_sum;
  logic [ProdW-17:0]          blend_res;
  logic                       pad_in_range;

  assign sens_eff = (sens_i == '0) ? tpcv_pkg::SensW'(1) : sens_i;
  assign sum_add  = (SumW+1)'(sum_q) + (SumW+1)'(deviation_i);
  assign pad_in_range = {1'b0, pos_q} < (PosW+1)'(Pads);

  // Shared multiplier; its product is always registered before further use.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      tpcv_pkg::DP_DEN: begin
        mul_a = MulW'(cnt_q);
        mul_b = MulW'(sens_eff);
      end
      tpcv_pkg::DP_MUL_SQ: begin
        mul_a = quot_q;
        mul_b = quot_q;
      end
      tpcv_pkg::DP_MUL_HS: begin
        mul_a = MulW'(held_q);
        mul_b = MulW'(s_q);
      end
      tpcv_pkg::DP_MUL_TR: begin
        mul_a = MulW'(tgt_q);
        mul_b = tpcv_pkg::QOne - MulW'(s_q);
      end
      tpcv_pkg::DP_MUL_DECAY: begin
        mul_a = MulW'(held_q);
        mul_b = MulW'(tpcv_pkg::Q095);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // One restoring step: the remainder is always below the divisor.
  assign trial    = {rem_q, quot_q[NormW-1]};
  assign trial_ge = trial >= NormW'(den_q);

  assign change     = (held_q >= tgt_q) ? (held_q - tgt_q) : (tgt_q - held_q);
  assign two_change = {change, 1'b0};

  assign blend_sum = ProdW'(acc_q) + prod_q + ProdW'(tpcv_pkg::QHalf);
  assign blend_res = blend_sum[ProdW-1:16];

  always_comb begin
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    mask_d      = mask_q;
    held_d      = held_q;
    held_mask_d = held_mask_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_cnt_d   = div_cnt_q;
    den_d       = den_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    tgt_d       = tgt_q;
    s_d         = s_q;
    out_mask_d  = out_mask_q;
    out_val_d   = out_val_q;

    if (cmd_i.accumulate && present_i) begin
      if (pad_in_range && pad_touched_i) begin
        if (sum_add > (SumW+1)'(signed'(tpcv_pkg::SumMax))) begin
          sum_d = tpcv_pkg::SumMax;
        end else if (sum_add < (SumW+1)'(signed'(tpcv_pkg::SumMin))) begin
          sum_d = tpcv_pkg::SumMin;
        end else begin
          sum_d = sum_add[SumW-1:0];
        end
        if (cnt_q != tpcv_pkg::CntMax) begin
          cnt_d = cnt_q + CntW'(1);
        end
        if ({1'b0, pos_q} < (PosW+1)'(MaskW)) begin
          mask_d = mask_q | (MaskW'(1) << pos_q);
        end
      end
      if (pos_q != tpcv_pkg::PosMax) begin
        pos_d = pos_q + PosW'(1);
      end
    end

    case (cmd_i.op)
      tpcv_pkg::DP_DEN: begin
        den_d = mul_p[DenW-1:0];
      end
      tpcv_pkg::DP_SAT: begin
        quot_d = NormW'(tpcv_pkg::QOne);
      end
      tpcv_pkg::DP_DIV_INIT: begin
        // Dividend is sum * 65536; its top part sum/2 is already below the divisor.
        rem_d     = sum_q[DenW:1];
        quot_d    = {sum_q[0], {(NormW-1){1'b0}}};
        div_cnt_d = '0;
      end
      tpcv_pkg::DP_DIV_STEP: begin
        rem_d     = trial_ge ? DenW'(trial - NormW'(den_q)) : trial[DenW-1:0];
        quot_d    = {quot_q[NormW-2:0], trial_ge};
        div_cnt_d = div_cnt_q + tpcv_pkg::DivCntW'(1);
      end
      tpcv_pkg::DP_TGT_ZERO: begin
        tgt_d = '0;
      end
      tpcv_pkg::DP_MUL_SQ, tpcv_pkg::DP_MUL_HS, tpcv_pkg::DP_MUL_DECAY: begin
        prod_d = mul_p;
      end
      tpcv_pkg::DP_TGT: begin
        tgt_d = (prod_q[ProdW-1:32] != '0) ? {ValW{1'b1}} : prod_q[31:16];
      end
      tpcv_pkg::DP_SMOOTH: begin
        s_d = (two_change > tpcv_pkg::SmoothSpan) ? tpcv_pkg::QHalf
            : ValW'((ValW+1)'(tpcv_pkg::Q095) - two_change);
      end
      tpcv_pkg::DP_MUL_TR: begin
        acc_d  = prod_q[AccW-1:0];
        prod_d = mul_p;
      end
      tpcv_pkg::DP_BLEND: begin
        held_d = (blend_res[ProdW-17:ValW] != '0) ? {ValW{1'b1}} : blend_res[ValW-1:0];
      end
      tpcv_pkg::DP_DECAY: begin
        held_d = prod_q[31:16];
      end
      default: begin
      end
    endcase

    if (cmd_i.load_out) begin
      if (present_i) begin
        held_mask_d = mask_q;
      end
      out_mask_d  = present_i ? mask_q : held_mask_q;
      out_val_d   = held_q;
      out_valid_d = 1'b1;
      sum_d       = '0;
      cnt_d       = '0;
      pos_d       = '0;
      mask_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      mask_q      <= '0;
      held_q      <= '0;
      held_mask_q <= '0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      mask_q      <= mask_d;
      held_q      <= held_d;
      held_mask_q <= held_mask_d;
      out_valid_q <= out_valid_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q      <= den_d;
    rem_q      <= rem_d;
    quot_q     <= quot_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    tgt_q      <= tgt_d;
    s_q        <= s_d;
    out_mask_q <= out_mask_d;
    out_val_q  <= out_val_d;
  end

  always_comb begin
    stat_o.present    = present_i;
    stat_o.count_zero = (cnt_q == '0);
    stat_o.sum_pos    = !sum_q[SumW-1] && (sum_q[SumW-2:0] != '0);
    stat_o.sat        = sum_q[SumW-2:0] >= (SumW-1)'({den_q, 1'b0});
    stat_o.div_last   = (div_cnt_q == tpcv_pkg::DivLast);
    stat_o.out_busy   = out_valid_q && !out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign touch_mask_o = out_mask_q;
  assign cv_value_o   = out_val_q;

endmodule

`default_nettype wire

/* hdl/touch_pressure_cv_smoother_unit.sv */
// Top level of the touch pressure control value smoother.
//
//   channel   direction  payload                                  handshake
//   in_ch     sink       pad_touched, deviation[15:0], last_pad   valid/ready
//   out_ch    source     touch_mask[11:0], cv_value[15:0]          valid/ready
//   cfg       write      cfg_idx_i[0], cfg_wdata_i[11:0]           cfg_we_i
//
// Pad items that are not last in their poll are accepted while idle. A last item
// with the sensor present runs the 17-step restoring divider or clamps at full
// scale, or takes a zero target if the sum is not positive; with no pad touched
// the held value decays, and with the sensor absent the sequencer skips to its
// final step. The result sits in an output register; a stalled output holds the
// sequencer in its final step. Reset is asynchronous and clears all poll state.
`default_nettype none

module touch_pressure_cv_smoother_unit #(
  parameter int unsigned PADS = 12
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tpcv_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [tpcv_pkg::CfgDataW-1:0]     cfg_wdata_i,
  tpcv_in_if.sink                                in_ch,
  tpcv_out_if.source                             out_ch
);

  logic                         present_q, present_d;
  logic [tpcv_pkg::SensW-1:0]   sens_q, sens_d;
  tpcv_pkg::tpcv_cmd_t          cmd;
  tpcv_pkg::tpcv_stat_t         stat;
  logic                         in_ready;

  always_comb begin
    present_d = present_q;
    sens_d    = sens_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tpcv_pkg::CfgSensorPresent: present_d = cfg_wdata_i[0];
        tpcv_pkg::CfgSensitivity:   sens_d    = cfg_wdata_i[tpcv_pkg::SensW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      sens_q    <= tpcv_pkg::SensReset;
    end else begin
      present_q <= present_d;
      sens_q    <= sens_d;
    end
  end

  tpcv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_last_i  (in_ch.last_pad),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tpcv_dp #(
    .Pads (PADS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .present_i     (present_q),
    .sens_i        (sens_q),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .pad_touched_i (in_ch.pad_touched),
    .deviation_i   (in_ch.deviation),
    .out_ready_i   (out_ch.ready),
    .out_valid_o   (out_ch.valid),
    .touch_mask_o  (out_ch.touch_mask),
    .cv_value_o    (out_ch.cv_value)
  );

  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire
